// ===== design/ilst_pkg.sv =====
package ilst_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int POS_W        = 6;
    localparam int IDX_W        = 10;
    localparam int VAL_W        = 32;

    localparam logic [2:0] MODE_APPEND  = 3'd0;
    localparam logic [2:0] MODE_PREPEND = 3'd1;
    localparam logic [2:0] MODE_INSERT  = 3'd2;
    localparam logic [2:0] MODE_ERASE   = 3'd3;
    localparam logic [2:0] MODE_READ    = 3'd4;
    localparam logic [2:0] MODE_SWAP    = 3'd5;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWAP
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE,
        CELL_SWAP
    } cell_op_t;

    typedef struct packed {
        cell_op_t                op;
        logic [IDX_W-1:0]        pos;
        logic [IDX_W-1:0]        pos2;
        logic signed [VAL_W-1:0] wdata;
        logic signed [VAL_W-1:0] wdata2;
    } cell_ctl_t;

    typedef struct packed {
        logic [2:0]              mode;
        logic [POS_W-1:0]        position;
        logic [POS_W-1:0]        other_position;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [1:0]              status;
        logic [6:0]              count;
    } rsp_t;

endpackage

// ===== design/ilst_cell.sv =====
module ilst_cell
    import ilst_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic                    clk,
    input  cell_ctl_t               ctl,
    input  logic signed [VAL_W-1:0] prev_val,
    input  logic signed [VAL_W-1:0] next_val,
    output logic signed [VAL_W-1:0] val,
    output logic signed [VAL_W-1:0] rd_a,
    output logic signed [VAL_W-1:0] rd_b
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [VAL_W-1:0] val_reg;
    logic signed [VAL_W-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (MY_IDX == ctl.pos)
                    val_next = ctl.wdata;
                else if (MY_IDX > ctl.pos)
                    val_next = prev_val;
            end
            CELL_ERASE:
            begin
                if (MY_IDX >= ctl.pos)
                    val_next = next_val;
            end
            CELL_SWAP:
            begin
                if (MY_IDX == ctl.pos)
                    val_next = ctl.wdata;
                else if (MY_IDX == ctl.pos2)
                    val_next = ctl.wdata2;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val  = val_reg;
    assign rd_a = (MY_IDX == ctl.pos)  ? val_reg : '0;
    assign rd_b = (MY_IDX == ctl.pos2) ? val_reg : '0;

endmodule

// ===== design/indexed_list_store_unit.sv =====
// Channel   Signals                 Transfer
// request   start, busy, request    taken at an edge with start high and busy low
// result    done, result            valid for the one cycle that done is high
//
// Append, prepend, insert, erase, read: each request is latched, then executed.
// Swap: latch, gather both entries over the cell read bus, write back (skipped when out of range).
// busy is low only in idle; done rises in the cycle after the last work cycle.
// Reset clears the count and control; entry contents stay undefined until written.
// The receiver cannot stall; each result is shown exactly once.
module indexed_list_store_unit
    import ilst_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t result
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_VAL = CW'(CAPACITY);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic done_reg, done_next;
    rsp_t rsp_reg, rsp_next;
    req_t req_reg;
    logic signed [VAL_W-1:0] a_reg, a_next;
    logic signed [VAL_W-1:0] b_reg, b_next;

    cell_ctl_t ctl;
    logic signed [VAL_W-1:0] vals   [CAPACITY];
    logic signed [VAL_W-1:0] rda    [CAPACITY];
    logic signed [VAL_W-1:0] rdb    [CAPACITY];
    logic signed [VAL_W-1:0] rd_a_all, rd_b_all;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [VAL_W-1:0] prev_v, next_v;
            if (gi == 0)
            begin : g_first
                assign prev_v = '0;
            end
            else
            begin : g_mid
                assign prev_v = vals[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_v = '0;
            end
            else
            begin : g_inner
                assign next_v = vals[gi+1];
            end
            ilst_cell #(.INDEX(gi)) u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .prev_val (prev_v),
                .next_val (next_v),
                .val      (vals[gi]),
                .rd_a     (rda[gi]),
                .rd_b     (rdb[gi])
            );
        end
    endgenerate

    always_comb
    begin
        rd_a_all = '0;
        rd_b_all = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_a_all = rd_a_all | rda[i];
            rd_b_all = rd_b_all | rdb[i];
        end
    end

    logic [CMPW-1:0] cnt_c, pos_c, pos2_c;
    logic full, pos_ok, pos2_ok;
    logic [CW+6:0] cnt_ext;

    assign cnt_c   = CMPW'(count_reg);
    assign pos_c   = CMPW'(req_reg.position);
    assign pos2_c  = CMPW'(req_reg.other_position);
    assign full    = (count_reg == CAP_VAL);
    assign pos_ok  = (pos_c < cnt_c);
    assign pos2_ok = (pos2_c < cnt_c);
    assign cnt_ext = {7'd0, count_next};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (req_reg.mode == MODE_SWAP && pos_ok && pos2_ok)
                    state_next = ST_SWAP;
                else
                    state_next = ST_IDLE;
            end
            ST_SWAP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl.op     = CELL_HOLD;
        ctl.pos    = IDX_W'(req_reg.position);
        ctl.pos2   = IDX_W'(req_reg.other_position);
        ctl.wdata  = req_reg.value;
        ctl.wdata2 = '0;
        count_next = count_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        rsp_next.read_value = '0;
        rsp_next.status     = STAT_OK;
        rsp_next.count      = '0;
        case (state_reg)
            ST_EXEC:
            begin
                done_next = 1'b1;
                case (req_reg.mode)
                    MODE_APPEND, MODE_PREPEND, MODE_INSERT:
                    begin
                        if (full)
                            rsp_next.status = STAT_FULL;
                        else
                        begin
                            ctl.op = CELL_INSERT;
                            if (req_reg.mode == MODE_APPEND)
                                ctl.pos = IDX_W'(count_reg);
                            else if (req_reg.mode == MODE_PREPEND)
                                ctl.pos = '0;
                            else if (!pos_ok)
                                ctl.pos = IDX_W'(count_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    MODE_ERASE:
                    begin
                        if (!pos_ok)
                            rsp_next.status = STAT_RANGE;
                        else
                        begin
                            ctl.op = CELL_ERASE;
                            count_next = count_reg - CW'(1);
                        end
                    end
                    MODE_READ:
                    begin
                        if (!pos_ok)
                            rsp_next.status = STAT_RANGE;
                        else
                            rsp_next.read_value = rd_a_all;
                    end
                    MODE_SWAP:
                    begin
                        if (!(pos_ok && pos2_ok))
                            rsp_next.status = STAT_RANGE;
                        else
                        begin
                            done_next = 1'b0;
                            a_next = rd_a_all;
                            b_next = rd_b_all;
                        end
                    end
                    default:
                    begin
                        rsp_next.status = STAT_OK;
                    end
                endcase
            end
            ST_SWAP:
            begin
                done_next  = 1'b1;
                ctl.op     = CELL_SWAP;
                ctl.wdata  = b_reg;
                ctl.wdata2 = a_reg;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
        rsp_next.count = cnt_ext[6:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
            req_reg <= request;
        rsp_reg <= rsp_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import ilst_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int PRINT_LIMIT = 40;
    localparam logic [2:0] MODE_RSVD_LO = 3'd6;
    localparam logic [2:0] MODE_RSVD_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t request = '0;
    logic done;
    rsp_t result;

    logic signed [VAL_W-1:0] model_cells [0:CAP-1];
    int model_count = 0;
    rsp_t list_rsp_q [$];
    int bad_fields = 0;
    int stall_cycles = 0;
    bit quiet_tail = 1'b0;

    indexed_list_store_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic rsp_t apply_list_op(req_t r);
        rsp_t o;
        int p;
        int i;
        int pa;
        int pb;
        logic signed [VAL_W-1:0] t;
        o = '0;
        o.status = STAT_OK;
        pa = int'(r.position);
        pb = int'(r.other_position);
        case (r.mode)
            MODE_APPEND, MODE_PREPEND, MODE_INSERT:
            begin
                if (model_count >= CAP)
                begin
                    o.status = STAT_FULL;
                end
                else
                begin
                    if (r.mode == MODE_APPEND)
                        p = model_count;
                    else if (r.mode == MODE_PREPEND)
                        p = 0;
                    else
                        p = (pa < model_count) ? pa : model_count;
                    for (i = model_count; i > p; i--)
                        model_cells[i] = model_cells[i-1];
                    model_cells[p] = r.value;
                    model_count++;
                end
            end
            MODE_ERASE:
            begin
                if (pa >= model_count)
                begin
                    o.status = STAT_RANGE;
                end
                else
                begin
                    for (i = pa; i + 1 < model_count; i++)
                        model_cells[i] = model_cells[i+1];
                    model_count--;
                end
            end
            MODE_READ:
            begin
                if (pa >= model_count)
                    o.status = STAT_RANGE;
                else
                    o.read_value = model_cells[r.position];
            end
            MODE_SWAP:
            begin
                if (pa >= model_count || pb >= model_count)
                begin
                    o.status = STAT_RANGE;
                end
                else
                begin
                    t = model_cells[r.position];
                    model_cells[r.position] = model_cells[r.other_position];
                    model_cells[r.other_position] = t;
                end
            end
            default:
            begin
            end
        endcase
        o.count = 7'(model_count);
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (bad_fields < PRINT_LIMIT)
            $display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
        bad_fields++;
    endtask

    // request stays up until taken; start is lowered only by an idle gap or at the end of the test
    task automatic send_request(req_t r);
        start <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        list_rsp_q.push_back(apply_list_op(r));
    endtask

    task automatic idle_gap(int n);
        start <= 1'b0;
        request <= req_t'({$urandom, $urandom});
        repeat (n) @(posedge clk);
    endtask

    task automatic maybe_idle();
        if (!quiet_tail && $urandom_range(0, 3) == 0)
            idle_gap($urandom_range(1, 11));
    endtask

    task automatic issue(logic [2:0] m, int p, int p2, logic signed [VAL_W-1:0] v);
        req_t r;
        r.mode = m;
        r.position = POS_W'(p);
        r.other_position = POS_W'(p2);
        r.value = v;
        send_request(r);
        maybe_idle();
    endtask

    function automatic logic [POS_W-1:0] pick_pos();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (model_count > 0 && roll < 7)
            return POS_W'($urandom_range(0, model_count - 1));
        else if (roll < 8)
            return POS_W'(model_count);
        else
            return POS_W'($urandom);
    endfunction

    function automatic req_t pick_request(int unsigned grow_pct);
        req_t r;
        int unsigned roll;
        r.value = $urandom;
        r.position = pick_pos();
        r.other_position = pick_pos();
        roll = $urandom_range(0, 99);
        if (roll < grow_pct)
        begin
            case ($urandom_range(0, 2))
                0: r.mode = MODE_APPEND;
                1: r.mode = MODE_PREPEND;
                default: r.mode = MODE_INSERT;
            endcase
        end
        else if (roll < 98)
        begin
            case ($urandom_range(0, 3))
                0, 1: r.mode = MODE_ERASE;
                2: r.mode = MODE_READ;
                default: r.mode = MODE_SWAP;
            endcase
        end
        else
        begin
            r.mode = $urandom_range(0, 1) ? MODE_RSVD_HI : MODE_RSVD_LO;
        end
        return r;
    endfunction

    task automatic test_empty_store();
        issue(MODE_READ, 0, 0, 0);
        issue(MODE_ERASE, 0, 0, 0);
        issue(MODE_SWAP, 0, 0, 0);
        issue(MODE_RSVD_LO, 63, 63, 32'hFFFFFFFF);
        issue(MODE_RSVD_HI, 0, 0, 0);
    endtask

    task automatic test_insert_paths();
        issue(MODE_INSERT, 63, 0, 32'sh7FFFFFFF);
        issue(MODE_PREPEND, 0, 0, 32'sh80000000);
        issue(MODE_APPEND, 0, 0, 0);
        issue(MODE_INSERT, 1, 0, -1);
        issue(MODE_INSERT, 0, 0, 32'sh55555555);
        issue(MODE_INSERT, 5, 0, 32'shAAAAAAAA);
    endtask

    task automatic test_read_swap();
        int i;
        for (i = 0; i < 6; i++)
            issue(MODE_READ, i, 0, 0);
        issue(MODE_SWAP, 0, 0, 0);
        issue(MODE_SWAP, 1, 5, 0);
        issue(MODE_SWAP, 2, 6, 0);
        issue(MODE_SWAP, 6, 2, 0);
        issue(MODE_READ, 6, 0, 0);
    endtask

    task automatic test_erase_paths();
        issue(MODE_ERASE, 5, 0, 0);
        issue(MODE_ERASE, 0, 0, 0);
        issue(MODE_ERASE, 63, 63, 0);
        issue(MODE_READ, 1, 0, 0);
    endtask

    // fill past full, drain past empty, then a mixed stretch with no gaps at the end
    task automatic test_random_traffic();
        int i;
        for (i = 0; i < 170; i++)
        begin
            send_request(pick_request(75));
            maybe_idle();
        end
        for (i = 0; i < 170; i++)
        begin
            send_request(pick_request(5));
            maybe_idle();
        end
        for (i = 0; i < 60; i++)
        begin
            if (i == 30)
                quiet_tail = 1'b1;
            send_request(pick_request(50));
            maybe_idle();
        end
    endtask

    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && done)
        begin
            if (list_rsp_q.size() == 0)
            begin
                report_mismatch("result with no request", {25'b0, result.count}, 0);
            end
            else
            begin
                want = list_rsp_q.pop_front();
                if (result.read_value !== want.read_value)
                    report_mismatch("read_value", result.read_value, want.read_value);
                if (result.status !== want.status)
                    report_mismatch("status", {30'b0, result.status}, {30'b0, want.status});
                if (result.count !== want.count)
                    report_mismatch("count", {25'b0, result.count}, {25'b0, want.count});
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_store();
        test_insert_paths();
        test_read_swap();
        test_erase_paths();
        test_random_traffic();
        start <= 1'b0;
        while (list_rsp_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (bad_fields == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
design/ilst_pkg.sv
design/ilst_cell.sv
design/indexed_list_store_unit.sv
tb/sv/testbench.sv
